### src/sfod_pkg.sv
package sfod_pkg;

  // Widths fixed by the sensor and the configuration registers.
  localparam int DIST_W   = 16;
  localparam int DELTA_W  = 17;
  localparam int PERIOD_W = 10;
  localparam int TICK_W   = 14;
  localparam int RISE_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Tick counter wraps to zero after this count.
  localparam logic [TICK_W-1:0] TICK_WRAP = 14'd10000;

  // Rises counted before the next one sets the obstacle flag.
  localparam logic [RISE_W-1:0] RISES_NEEDED = 2'd2;

  // Register reset values.
  localparam logic [PERIOD_W-1:0]      PERIOD_RESET = 10'd50;
  localparam logic signed [DIST_W-1:0] ALERT_RESET  = 16'sd20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALERT_DISTANCE = 1'b1;

  // Input item.
  typedef struct packed {
    logic                      cmd;
    logic signed [DIST_W-1:0]  reading;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [DIST_W-1:0]  held_distance;
    logic signed [DIST_W-1:0]  filtered_distance;
    logic                      alert;
    logic                      obstacle;
  } out_t;

endpackage

### src/sfod_mean.sv
// Window mean, truncated toward zero, and the alert band compare.
// The divide by WINDOW is a multiplication by a rounded-up reciprocal,
// exact for every magnitude the window sum can reach.
module sfod_mean #(
  parameter int WINDOW = 8,
  parameter int SUM_W  = 16 + $clog2(WINDOW)
) (
  input  logic signed [SUM_W-1:0]              sum,
  input  logic signed [sfod_pkg::DIST_W-1:0]   alert_distance,
  output logic signed [sfod_pkg::DIST_W-1:0]   filtered,
  output logic                                 alert
);

  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic                          sum_neg;
  logic [SUM_W-1:0]              mag;
  logic [PROD_W-1:0]             prod;
  logic [sfod_pkg::DIST_W-1:0]   quot;

  // Divide the magnitude, then restore the sign.
  always_comb begin
    sum_neg  = sum[SUM_W-1];
    mag      = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
    prod     = PROD_W'(mag) * PROD_W'(RECIP);
    quot     = prod[SHIFT +: sfod_pkg::DIST_W];
    filtered = sum_neg ? $signed(-quot) : $signed(quot);
    alert    = !filtered[sfod_pkg::DIST_W-1] && (filtered <= alert_distance);
  end

endmodule

### src/sonar_filter_obstacle_detect_core.sv
// Throughput: one item per cycle when in_stall is low. Sampling state and
// the running window sum are updated in the transfer cycle (state stage);
// the mean is formed as the item enters the output register, out_data.
// A sample_period write starts a remainder pass, one bit a cycle between
// config writes, that realigns the sample phase to the tick counter; input
// stalls meanwhile. rst_n low (sync) zeroes sampling state, sum and window.
module sonar_filter_obstacle_detect_core #(
  parameter int WINDOW = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  sfod_pkg::in_t                          in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output sfod_pkg::out_t                         out_data,
  input  logic                                   cfg_we,
  input  logic [sfod_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sfod_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SUM_W = sfod_pkg::DIST_W + $clog2(WINDOW);
  localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);
  localparam int CNT_W = $clog2(sfod_pkg::TICK_W);

  // Configuration registers.
  logic [sfod_pkg::PERIOD_W-1:0]          period_r;
  logic signed [sfod_pkg::DIST_W-1:0]     alert_r;

  // Sampling state.
  logic signed [sfod_pkg::DIST_W-1:0]     held_r, held_nxt;
  logic signed [sfod_pkg::DIST_W-1:0]     prev_r, prev_nxt;
  logic signed [sfod_pkg::DELTA_W-1:0]    pdelta_r, pdelta_nxt;
  logic [sfod_pkg::RISE_W-1:0]            rise_r, rise_nxt;
  logic                                   obst_r, obst_nxt;
  logic [sfod_pkg::TICK_W-1:0]            tick_r, tick_nxt;
  logic [sfod_pkg::PERIOD_W-1:0]          rem_r, rem_nxt;

  // Window shift line and its running sum.
  logic signed [sfod_pkg::DIST_W-1:0]     win_r [WINDOW];
  logic signed [SUM_W-1:0]                sum_r, sum_nxt;

  // Remainder pass after a period write.
  logic                                   div_busy_r;
  logic [CNT_W-1:0]                       div_cnt_r;

  // Pipeline control.
  logic                                   s1_v_r;
  logic                                   out_v_r;
  sfod_pkg::out_t                         out_r;

  logic                                   out_ready;
  logic                                   s1_ready;
  logic                                   s1_move;
  logic                                   accept;

  logic [sfod_pkg::PERIOD_W-1:0]          period_eff;
  logic                                   do_sample;
  logic signed [sfod_pkg::DELTA_W-1:0]    delta;
  logic [sfod_pkg::PERIOD_W:0]            rem_inc;
  logic [sfod_pkg::PERIOD_W:0]            part;
  logic [sfod_pkg::PERIOD_W:0]            part_red;

  logic signed [sfod_pkg::DIST_W-1:0]     mean;
  logic                                   mean_alert;

  // Handshake: the state stage empties into the output register.
  assign out_ready = !out_v_r || !out_stall;
  assign s1_ready  = !s1_v_r || out_ready;
  assign s1_move   = s1_v_r && out_ready;
  assign in_stall  = div_busy_r || !s1_ready;
  assign accept    = in_valid && !in_stall;

  assign period_eff = (period_r == '0) ? sfod_pkg::PERIOD_W'(1) : period_r;

  // One restoring step of tick_count modulo the period.
  always_comb begin
    part     = {rem_r, tick_r[div_cnt_r]};
    part_red = (part >= {1'b0, period_eff}) ? part - {1'b0, period_eff} : part;
  end

  // Sampling, rise detection and tick advance for a tick item.
  always_comb begin
    held_nxt   = held_r;
    prev_nxt   = prev_r;
    pdelta_nxt = pdelta_r;
    rise_nxt   = rise_r;
    obst_nxt   = obst_r;
    tick_nxt   = tick_r;
    rem_nxt    = rem_r;
    do_sample  = (rem_r == '0);
    delta      = sfod_pkg::DELTA_W'(in_data.reading) - sfod_pkg::DELTA_W'(prev_r);
    rem_inc    = {1'b0, rem_r} + (sfod_pkg::PERIOD_W+1)'(1);

    if (do_sample) begin
      held_nxt = in_data.reading;
      prev_nxt = in_data.reading;
      if (!delta[sfod_pkg::DELTA_W-1] && (delta != '0) &&
          (pdelta_r[sfod_pkg::DELTA_W-1] || (pdelta_r == '0))) begin
        if (rise_r == sfod_pkg::RISES_NEEDED) begin
          obst_nxt   = 1'b1;
          pdelta_nxt = delta;
          rise_nxt   = '0;
        end else begin
          rise_nxt = rise_r + sfod_pkg::RISE_W'(1);
        end
      end else begin
        pdelta_nxt = delta;
        rise_nxt   = '0;
      end
    end

    if (tick_r == sfod_pkg::TICK_WRAP) begin
      tick_nxt = '0;
      rem_nxt  = '0;
    end else begin
      tick_nxt = tick_r + sfod_pkg::TICK_W'(1);
      rem_nxt  = (rem_inc == {1'b0, period_eff}) ? '0 : rem_inc[sfod_pkg::PERIOD_W-1:0];
    end
  end

  // Window sum: refill loads WINDOW copies, a tick pushes the new held value.
  always_comb begin
    if (in_data.cmd) begin
      sum_nxt = SUM_W'(held_r) * WIN_S;
    end else begin
      sum_nxt = sum_r - SUM_W'(win_r[WINDOW-1]) + SUM_W'(held_nxt);
    end
  end

  // Configuration, remainder pass and sampling state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= sfod_pkg::PERIOD_RESET;
      alert_r    <= sfod_pkg::ALERT_RESET;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      held_r     <= '0;
      prev_r     <= '0;
      pdelta_r   <= '0;
      rise_r     <= '0;
      obst_r     <= 1'b0;
      tick_r     <= '0;
      rem_r      <= '0;
      sum_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfod_pkg::CFG_SAMPLE_PERIOD: begin
            period_r   <= cfg_data[sfod_pkg::PERIOD_W-1:0];
            div_busy_r <= 1'b1;
            div_cnt_r  <= CNT_W'(sfod_pkg::TICK_W - 1);
            rem_r      <= '0;
          end
          sfod_pkg::CFG_ALERT_DISTANCE: begin
            alert_r <= $signed(cfg_data[sfod_pkg::DIST_W-1:0]);
          end
          default: begin
          end
        endcase
      end else if (div_busy_r) begin
        rem_r <= part_red[sfod_pkg::PERIOD_W-1:0];
        if (div_cnt_r == '0) begin
          div_busy_r <= 1'b0;
        end else begin
          div_cnt_r <= div_cnt_r - CNT_W'(1);
        end
      end

      if (accept) begin
        sum_r <= sum_nxt;
        if (!in_data.cmd) begin
          held_r   <= held_nxt;
          prev_r   <= prev_nxt;
          pdelta_r <= pdelta_nxt;
          rise_r   <= rise_nxt;
          obst_r   <= obst_nxt;
          tick_r   <= tick_nxt;
          rem_r    <= rem_nxt;
        end
      end
    end
  end

  // Window shift line; slot 0 holds the newest value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else if (accept) begin
      if (in_data.cmd) begin
        for (int i = 0; i < WINDOW; i++) begin
          win_r[i] <= held_r;
        end
      end else begin
        win_r[0] <= held_nxt;
        for (int i = 1; i < WINDOW; i++) begin
          win_r[i] <= win_r[i-1];
        end
      end
    end
  end

  // Mean and alert from the state left by the item in the state stage.
  sfod_mean #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_mean (
    .sum            (sum_r),
    .alert_distance (alert_r),
    .filtered       (mean),
    .alert          (mean_alert)
  );

  // Stage valids and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (out_ready) begin
        s1_v_r <= 1'b0;
      end

      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r.held_distance     <= held_r;
      out_r.filtered_distance <= mean;
      out_r.alert             <= mean_alert;
      out_r.obstacle          <= obst_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### src/sfod_checker.sv
// Port-level checks for the sonar filter core.
module sfod_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_stall,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  sfod_pkg::out_t                         out_data,
  input  logic                                   cfg_we,
  input  logic [sfod_pkg::CFG_IDX_W-1:0]         cfg_index
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // The obstacle flag, once reported, stays set while results follow back to back.
  a_obst_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.obstacle |=> !out_valid || out_data.obstacle)
    else $error("obstacle flag cleared");

  // Alert is only raised for a non-negative mean.
  a_alert_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alert |-> !out_data.filtered_distance[sfod_pkg::DIST_W-1])
    else $error("alert with negative filtered distance");

  // A period write holds off input while the sample phase is realigned.
  a_period_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == sfod_pkg::CFG_SAMPLE_PERIOD) |=> in_stall)
    else $error("input taken during phase realignment");

endmodule

bind sonar_filter_obstacle_detect_core sfod_checker u_sfod_checker (.*);
